@@ sv/atcl_pkg.sv @@
package atcl_pkg;

	typedef enum logic [3:0] {
		CMD_AT       = 4'd0,
		CMD_ATE0     = 4'd1,
		CMD_ATE1     = 4'd2,
		CMD_ATI      = 4'd3,
		CMD_SET_TIME = 4'd4,
		CMD_SET_DATE = 4'd5,
		CMD_Q_DOW    = 4'd6,
		CMD_SET_DOW  = 4'd7,
		CMD_Q_TIME   = 4'd8,
		CMD_Q_DATE   = 4'd9,
		CMD_Q_TEMP   = 4'd10,
		CMD_ATDP     = 4'd11,
		CMD_UNKNOWN  = 4'd12
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DECIDE,
		ST_WDAY,
		ST_OUT
	} state_t;

	// Bit positions of the candidate mask, one per pattern.
	localparam int NPAT = 12;
	localparam int P_AT = 0, P_ATE0 = 1, P_ATE1 = 2, P_ATI = 3, P_TIME = 4, P_DATE = 5,
		P_QDOW = 6, P_DOW = 7, P_QTIME = 8, P_QDATE = 9, P_QTEMP = 10, P_ATDP = 11;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic       line_done;
		logic [3:0] command;
		logic       failed;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [6:0] year_in_century;
		logic [2:0] weekday;
	} result_t;

	// Expected character of a pattern at a position; 0 past its end.
	function automatic logic [7:0] pat_char(input int p, input int i);
		string s;
		case (p)
			P_AT:    s = "AT";
			P_ATE0:  s = "ATE0";
			P_ATE1:  s = "ATE1";
			P_ATI:   s = "ATI";
			P_TIME:  s = "AT+TIME=";
			P_DATE:  s = "AT+DATE=";
			P_QDOW:  s = "AT+DOW?";
			P_DOW:   s = "AT+DOW=";
			P_QTIME: s = "AT+TIME?";
			P_QDATE: s = "AT+DATE?";
			P_QTEMP: s = "AT+TEMP?";
			default: s = "ATDP";
		endcase
		return (i < s.len()) ? 8'(s[i]) : 8'd0;
	endfunction

	function automatic int pat_len(input int p);
		case (p)
			P_AT:    return 2;
			P_ATI:   return 3;
			P_ATE0, P_ATE1, P_ATDP: return 4;
			P_QDOW, P_DOW: return 7;
			default: return 8;
		endcase
	endfunction

	function automatic logic [2:0] sak(input logic [3:0] m);
		case (m)
			4'd1: return 3'd0;  4'd2: return 3'd3;  4'd3: return 3'd2;
			4'd4: return 3'd5;  4'd5: return 3'd0;  4'd6: return 3'd3;
			4'd7: return 3'd5;  4'd8: return 3'd1;  4'd9: return 3'd4;
			4'd10: return 3'd6; 4'd11: return 3'd2; 4'd12: return 3'd4;
			default: return 3'd0;
		endcase
	endfunction

endpackage

@@ sv/atcl_stream_if.sv @@
interface atcl_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/atcl_ram.sv @@
module atcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/at_command_line_parser_core.sv @@
// AT command line parser.
// Channel rx carries one received byte per beat; channel res carries one
// result beat per received byte: the echo, and for a completed non-empty
// line the command code, OK/ERROR and the parsed set fields.
// An ordinary byte, backspace, or an empty line end passes through ST_WAIT
// before the result is offered. A non-empty line end scans the stored line
// out of the line RAM one character per cycle in ST_SCAN, then decides in
// ST_DECIDE; a valid set-date line also passes through ST_WDAY for the
// reduction of the weekday sum modulo 7.
// The block takes one byte at a time: rx.ready is low from acceptance until
// the result beat is taken. A stalled receiver simply holds the result
// beat; nothing is lost. Reset empties the line and turns echo on; the line
// RAM needs no clearing since only written entries are read.
module at_command_line_parser_core
	import atcl_pkg::*;
#(
	parameter int LINE_CHARS = 24
) (
	input logic clk,
	input logic arst_n,
	atcl_stream_if.sink   rx,
	atcl_stream_if.source res
);
	localparam int AW = $clog2(LINE_CHARS);
	localparam int LW = $clog2(LINE_CHARS + 1);

	state_t state_q, state_d;
	logic [LW-1:0] len_q;
	logic echo_q;
	logic [7:0] byte_q;
	logic [LW-1:0] idx_q;
	logic [NPAT-1:0] cand_q;
	logic [7:0] dig_q [6];
	result_t out_q;
	logic [9:0] wsum_q;

	logic [7:0] rdata;
	logic we;
	logic accept;
	logic is_end, is_bs;

	assign accept = rx.valid && rx.ready;
	assign rx.ready = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_OUT);
	assign res.data = out_q;
	assign is_end = (byte_q == CH_CR) || (byte_q == CH_LF);
	assign is_bs = (byte_q == CH_BS) || (byte_q == CH_DEL);

	assign we = accept && !(rx.data == CH_CR || rx.data == CH_LF ||
		rx.data == CH_BS || rx.data == CH_DEL) &&
		(32'(len_q) + 1 < LINE_CHARS);

	atcl_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line (
		.clk(clk), .we(we), .waddr(len_q[AW-1:0]), .wdata(rx.data),
		.raddr(idx_q[AW-1:0]), .rdata(rdata)
	);

	// Character at scan position idx_q-1 arrives on rdata in ST_SCAN.
	logic [LW-1:0] pos;
	logic [NPAT-1:0] cand_n;
	assign pos = idx_q - LW'(1);

	always_comb begin
		for (int p = 0; p < NPAT; p++) begin
			if (int'(pos) < pat_len(p))
				cand_n[p] = cand_q[p] && (rdata == pat_char(p, int'(pos)));
			else
				cand_n[p] = cand_q[p];
		end
	end

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic logic [6:0] two(input logic [7:0] a, input logic [7:0] b);
		return 7'((a - 8'd48) * 10 + (b - 8'd48));
	endfunction

	logic [6:0] v0, v1, v2;
	logic digs_ok, len14, len8;
	assign v0 = two(dig_q[0], dig_q[1]);
	assign v1 = two(dig_q[2], dig_q[3]);
	assign v2 = two(dig_q[4], dig_q[5]);
	assign digs_ok = is_dig(dig_q[0]) && is_dig(dig_q[1]) && is_dig(dig_q[2]) &&
		is_dig(dig_q[3]) && is_dig(dig_q[4]) && is_dig(dig_q[5]);
	assign len14 = (32'(len_q) == 14);
	assign len8 = (32'(len_q) == 8);

	// Since 8 is 1 modulo 7, the sum folds by adding its 3-bit groups.
	logic [4:0] wf1;
	logic [3:0] wf2;
	assign wf1 = 5'(wsum_q[9]) + 5'(wsum_q[8:6]) + 5'(wsum_q[5:3]) + 5'(wsum_q[2:0]);
	assign wf2 = 4'(wf1[4:3]) + 4'(wf1[2:0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_WAIT;
			ST_WAIT: begin
				if (is_end && len_q != '0) state_d = ST_SCAN;
				else state_d = ST_OUT;
			end
			ST_SCAN: if (idx_q == len_q) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (cand_q[P_DATE] && len14 && digs_ok && v0 >= 1 && v0 <= 31 &&
					v1 >= 1 && v1 <= 12 && !(cand_q[P_AT] && 32'(len_q) == 2))
					state_d = ST_WDAY;
				else state_d = ST_OUT;
			end
			ST_WDAY: state_d = ST_OUT;
			ST_OUT: if (res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			echo_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (we) len_q <= len_q + LW'(1);
			else if (state_q == ST_WAIT && is_bs && len_q != '0) len_q <= len_q - LW'(1);
			if (state_q == ST_DECIDE) begin
				len_q <= '0;
				if (cand_q[P_ATE0] && 32'(len_q) == 4) echo_q <= 1'b0;
				else if (cand_q[P_ATE1] && 32'(len_q) == 4) echo_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rx.data;
			out_q <= {echo_q, (echo_q ? rx.data : 8'd0), 42'd0};
			idx_q <= '0;
			cand_q <= '1;
		end
		case (state_q)
			ST_WAIT: idx_q <= LW'(1);
			ST_SCAN: begin
				cand_q <= cand_n;
				if (int'(pos) >= 8 && int'(pos) < 14) dig_q[3'(int'(pos) - 8)] <= rdata;
				if (int'(pos) == 7) dig_q[5] <= rdata;
				if (idx_q != len_q) idx_q <= idx_q + LW'(1);
			end
			ST_DECIDE: begin
				out_q.line_done <= 1'b1;
				if (cand_q[P_AT] && 32'(len_q) == 2) out_q.command <= CMD_AT;
				else if (cand_q[P_ATE0] && 32'(len_q) == 4) out_q.command <= CMD_ATE0;
				else if (cand_q[P_ATE1] && 32'(len_q) == 4) out_q.command <= CMD_ATE1;
				else if (cand_q[P_ATI] && 32'(len_q) == 3) out_q.command <= CMD_ATI;
				else if (cand_q[P_TIME] && len14) begin
					out_q.command <= CMD_SET_TIME;
					if (digs_ok && v0 <= 23 && v1 <= 59 && v2 <= 59) begin
						out_q.hour <= v0[4:0];
						out_q.minute <= v1[5:0];
						out_q.second <= v2[5:0];
					end else out_q.failed <= 1'b1;
				end else if (cand_q[P_DATE] && len14) begin
					out_q.command <= CMD_SET_DATE;
					if (digs_ok && v0 >= 1 && v0 <= 31 && v1 >= 1 && v1 <= 12) begin
						out_q.day_of_month <= v0[4:0];
						out_q.month <= v1[3:0];
						out_q.year_in_century <= v2;
					end else out_q.failed <= 1'b1;
				end else if (cand_q[P_QDOW] && 32'(len_q) == 7) out_q.command <= CMD_Q_DOW;
				else if (cand_q[P_DOW] && len8) begin
					out_q.command <= CMD_SET_DOW;
					if (dig_q[5] >= "1" && dig_q[5] <= "7") out_q.weekday <= dig_q[5][2:0];
					else out_q.failed <= 1'b1;
				end else if (cand_q[P_QTIME] && len8) out_q.command <= CMD_Q_TIME;
				else if (cand_q[P_QDATE] && len8) out_q.command <= CMD_Q_DATE;
				else if (cand_q[P_QTEMP] && len8) out_q.command <= CMD_Q_TEMP;
				else if (cand_q[P_ATDP] && 32'(len_q) >= 4) out_q.command <= CMD_ATDP;
				else begin
					out_q.command <= CMD_UNKNOWN;
					out_q.failed <= 1'b1;
				end
				// Year relative to 2000; Jan/Feb count in the previous year.
				// Year 2000 + w contributes 5 + w + 500 + w/4 - 20 + 5 modulo 7.
				if (v1 < 3) begin
					if (v2 == 0)
						wsum_q <= 10'(1999 % 7 + 1999/4 - 1999/100 + 1999/400)
							+ 10'(sak(v1[3:0])) + 10'(v0);
					else
						wsum_q <= 10'(v2 - 7'd1) + 10'((v2 - 7'd1) >> 2) + 10'(5 + 500 - 20 + 5)
							+ 10'(sak(v1[3:0])) + 10'(v0);
				end else
					wsum_q <= 10'(v2) + 10'(v2 >> 2) + 10'(5 + 500 - 20 + 5)
						+ 10'(sak(v1[3:0])) + 10'(v0);
			end
			ST_WDAY: begin
				out_q.weekday <= (wf2 == 4'd0 || wf2 == 4'd7) ? 3'd7 :
					(wf2 > 4'd7) ? 3'(wf2 - 4'd7) : wf2[2:0];
			end
			default: ;
		endcase
	end
endmodule

@@ sv/atcl_checker.sv @@
module atcl_checker
	import atcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	input logic rx_ready,
	input logic res_valid,
	input logic res_ready,
	input result_t res_data
);
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_ready && res_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped");
	a_done_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.line_done |-> res_data.command == CMD_AT && !res_data.failed)
		else $error("fields without line end");
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.failed |-> res_data.hour == 0 && res_data.weekday == 0)
		else $error("fields on error");
endmodule

bind at_command_line_parser_core atcl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rx_valid(rx.valid), .rx_ready(rx.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);

@@ sim/at_command_line_parser_core_tb.sv @@
`timescale 1ns / 100ps

module at_command_line_parser_core_tb;
	import atcl_pkg::*;

	localparam int LINE_CHARS = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	atcl_stream_if #(8) rx_if ();
	atcl_stream_if #($bits(result_t)) res_if ();

	at_command_line_parser_core #(.LINE_CHARS(LINE_CHARS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if.sink),
		.res(res_if.source)
	);

	always #5 clk = ~clk;

	logic [7:0] byte_q[$];
	result_t    expected_q[$];
	int         bytes_sent = 0;
	int         cycle_cnt = 0;
	int         errors = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;

	// Shadow state of the parser.
	logic [7:0] line_mem[LINE_CHARS];
	int         line_len = 0;
	bit         echo_en = 1'b1;

	function automatic bit line_eq(string s);
		if (line_len != s.len()) return 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (line_mem[i] != 8'(s[i])) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit line_begins(string s);
		if (line_len < s.len()) return 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (line_mem[i] != 8'(s[i])) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int digit_pair(int p);
		logic [7:0] a, b;
		a = line_mem[p];
		b = line_mem[p + 1];
		if (a < "0" || a > "9" || b < "0" || b > "9") return -1;
		return (a - "0") * 10 + (b - "0");
	endfunction

	function automatic int iso_dow(int y, int m, int d);
		int t[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		int s;
		if (m < 3) y = y - 1;
		s = (y + y / 4 - y / 100 + y / 400 + t[m - 1] + d) % 7;
		return (s == 0) ? 7 : s;
	endfunction

	function automatic void run_line(ref result_t r);
		int a, b, c;
		r.line_done = 1'b1;
		if (line_eq("AT")) r.command = CMD_AT;
		else if (line_eq("ATE0")) begin
			echo_en = 1'b0;
			r.command = CMD_ATE0;
		end else if (line_eq("ATE1")) begin
			echo_en = 1'b1;
			r.command = CMD_ATE1;
		end else if (line_eq("ATI")) r.command = CMD_ATI;
		else if (line_begins("AT+TIME=") && line_len == 14) begin
			a = digit_pair(8); b = digit_pair(10); c = digit_pair(12);
			r.command = CMD_SET_TIME;
			if (a >= 0 && a <= 23 && b >= 0 && b <= 59 && c >= 0 && c <= 59) begin
				r.hour = a; r.minute = b; r.second = c;
			end else
				r.failed = 1'b1;
		end else if (line_begins("AT+DATE=") && line_len == 14) begin
			a = digit_pair(8); b = digit_pair(10); c = digit_pair(12);
			r.command = CMD_SET_DATE;
			if (a >= 1 && a <= 31 && b >= 1 && b <= 12 && c >= 0) begin
				r.day_of_month = a; r.month = b; r.year_in_century = c;
				r.weekday = iso_dow(2000 + c, b, a);
			end else
				r.failed = 1'b1;
		end else if (line_eq("AT+DOW?")) r.command = CMD_Q_DOW;
		else if (line_begins("AT+DOW=") && line_len == 8) begin
			r.command = CMD_SET_DOW;
			if (line_mem[7] >= "1" && line_mem[7] <= "7")
				r.weekday = line_mem[7] - "0";
			else
				r.failed = 1'b1;
		end else if (line_eq("AT+TIME?")) r.command = CMD_Q_TIME;
		else if (line_eq("AT+DATE?")) r.command = CMD_Q_DATE;
		else if (line_eq("AT+TEMP?")) r.command = CMD_Q_TEMP;
		else if (line_begins("ATDP")) r.command = CMD_ATDP;
		else begin
			r.command = CMD_UNKNOWN;
			r.failed = 1'b1;
		end
	endfunction

	function automatic result_t parse_byte(logic [7:0] c);
		result_t r;
		r = '0;
		if (echo_en) begin
			r.echo_valid = 1'b1;
			r.echo_char = c;
		end
		if (c == CH_CR || c == CH_LF) begin
			if (line_len > 0) begin
				run_line(r);
				line_len = 0;
			end
		end else if (c == CH_BS || c == CH_DEL) begin
			if (line_len > 0) line_len--;
		end else if (line_len + 1 < LINE_CHARS) begin
			line_mem[line_len] = c;
			line_len++;
		end
		return r;
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) byte_q.push_back(8'(s[i]));
	endtask

	task automatic push_line(string s);
		push_text(s);
		byte_q.push_back(($urandom_range(1) != 0) ? CH_CR : CH_LF);
	endtask

	function automatic string pair_text(int hi);
		int v;
		case ($urandom_range(9))
			0: return $sformatf("%c%c", $urandom_range(255), 8'h30 + $urandom_range(9));
			1: v = $urandom_range(99);
			default: v = $urandom_range(hi);
		endcase
		return $sformatf("%02d", v);
	endfunction

	task automatic push_random_line();
		string s;
		int k;
		case ($urandom_range(15))
			0: s = "AT";
			1: s = "ATE0";
			2: s = "ATE1";
			3: s = "ATI";
			4: s = {"AT+TIME=", pair_text(23), pair_text(59), pair_text(59)};
			5: s = {"AT+DATE=", pair_text(31), pair_text(12), pair_text(99)};
			6: s = "AT+DOW?";
			7: s = $sformatf("AT+DOW=%c", 8'h30 + $urandom_range(9));
			8: s = "AT+TIME?";
			9: s = "AT+DATE?";
			10: s = "AT+TEMP?";
			11: s = $sformatf("ATDP%0d", $urandom_range(99999));
			12: s = "at";
			default: s = "";
		endcase
		if (s.len() == 0) begin
			// Noise: random bytes, with a line end sometimes mixed in.
			k = $urandom_range(12);
			for (int i = 0; i < k; i++) byte_q.push_back(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(7) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
		if ($urandom_range(7) == 0) begin
			push_text(s.substr(0, $urandom_range(s.len() - 1)));
			byte_q.push_back(($urandom_range(1) != 0) ? CH_BS : CH_DEL);
			byte_q.push_back(8'h41);
			byte_q.push_back(CH_DEL);
			push_line("");
		end else
			push_line(s);
	endtask

	// Sender: one beat at a time, idling depending on the phase of the run.
	always @(posedge clk or negedge arst_n) begin
		int phase;
		bit idle;
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.data <= '0;
		end else if (!rx_if.valid || rx_if.ready) begin
			phase = (bytes_sent / 150) % 4;
			idle = (phase == 1 && $urandom_range(99) < 75) ||
				(phase == 3 && $urandom_range(99) < 16);
			if (byte_q.size() > 0 && !idle) begin
				rx_if.data <= byte_q.pop_front();
				rx_if.valid <= 1'b1;
				bytes_sent <= bytes_sent + 1;
			end else
				rx_if.valid <= 1'b0;
		end
	end

	// Receiver: random stalls, and one long hold-off while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin
		int phase;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			phase = (bytes_sent / 150) % 4;
			if (!hold_done && bytes_sent >= 60) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				res_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_if.ready <= 1'b0;
			end else if (phase == 2)
				res_if.ready <= ($urandom_range(99) >= 75);
			else if (phase == 3)
				res_if.ready <= ($urandom_range(99) >= 16);
			else
				res_if.ready <= 1'b1;
		end
	end

	task automatic check_field(string name, int e, int a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			errors++;
		end
	endtask

	// Monitor: predict on every accepted byte, compare every accepted result.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			cycle_cnt <= cycle_cnt + 1;
			if (rx_if.valid && rx_if.ready) expected_q.push_back(parse_byte(rx_if.data));
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				if (expected_q.size() == 0) begin
					$error("result beat with no expected result");
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("echo_valid", want.echo_valid, got.echo_valid);
					check_field("echo_char", want.echo_char, got.echo_char);
					check_field("line_done", want.line_done, got.line_done);
					check_field("command", want.command, got.command);
					check_field("failed", want.failed, got.failed);
					check_field("hour", want.hour, got.hour);
					check_field("minute", want.minute, got.minute);
					check_field("second", want.second, got.second);
					check_field("day_of_month", want.day_of_month, got.day_of_month);
					check_field("month", want.month, got.month);
					check_field("year_in_century", want.year_in_century,
						got.year_in_century);
					check_field("weekday", want.weekday, got.weekday);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		push_line("AT");
		push_line("ATE0");
		push_line("ATI");
		push_line("ATE1");
		push_line("AT+TIME=235959");
		push_line("AT+TIME=000000");
		push_line("AT+TIME=240000");
		push_line("AT+TIME=12345");
		push_line("AT+DATE=311299");
		push_line("AT+DATE=010100");
		push_line("AT+DATE=001300");
		push_line("AT+DOW?");
		push_line("AT+DOW=7");
		push_line("AT+DOW=0");
		push_line("AT+TIME?");
		push_line("AT+DATE?");
		push_line("AT+TEMP?");
		push_line("ATDP5551234");
		push_line("");
		byte_q.push_back(CH_BS);
		byte_q.push_back(CH_DEL);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		push_line("");
		push_line("ATDP0123456789012345678901234");
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (byte_q.size() < 800) push_random_line();
		push_line("ATE1");
		wait (byte_q.size() == 0 && !rx_if.valid);
		wait (expected_q.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
